FILE: design/pba_pkg.sv
// Package for the pool block allocator: operation and status codes, word types, states.
package pba_pkg;

    // Operation codes
    localparam logic [1:0] OP_FIRST = 2'd0;
    localparam logic [1:0] OP_BEST  = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOFIT   = 3'd1,
        ST_ZERO    = 3'd2,
        ST_NULL    = 3'd3,
        ST_DOUBLE  = 3'd4,
        ST_INVALID = 3'd5
    } status_t;

    // Request word
    typedef struct packed {
        logic [1:0]  operation;
        logic [12:0] request_size;
        logic [11:0] free_addr;
    } in_t;

    // Result word
    typedef struct packed {
        logic [11:0] user_offset;
        status_t     status;
        logic [8:0]  used_blocks;
    } out_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_WRD,
        S_WEV,
        S_PLAN,
        S_SHRD,
        S_SHWR,
        S_FIN1,
        S_FIN2,
        S_DONE
    } state_t;

endpackage

FILE: design/pba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: design/pool_block_allocator_top.sv
// Top level of the pool block allocator: block table RAM and its sequencer.
//
// The pool is kept as an address-ordered table of blocks, one RAM word per
// block holding its user size and free mark; block starts follow from a
// running sum during each walk. A request walks the table block by block, and moves
// blocks when a split or a merge shifts the tail of the table. Requests that fail
// at once (zero size, null free, unknown operation) skip the walk. After reset
// the S_INIT state writes the initial block before the first request is taken.
// A new request is taken while a finished result still waits at the output.
module pool_block_allocator_top
    import pba_pkg::*;
#(
    parameter int POOL_BYTES   = 4096,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_BLOCKS   = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_word,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_word
);

    localparam int AW = $clog2(POOL_BYTES + 1);
    localparam int W  = ((AW > 13) ? AW : 13) + 1;
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [W-1:0]  HDR      = W'(HEADER_BYTES);
    localparam logic [W-1:0]  INIT_SZ  = W'(POOL_BYTES - HEADER_BYTES);
    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0] ONE      = CW'(1);

    state_t        state_reg, state_next;
    logic [1:0]    op_reg, op_next;
    logic [W-1:0]  want_reg, want_next;
    logic [W-1:0]  addr_reg, addr_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [W-1:0]  start_reg, start_next;
    logic          found_reg, found_next;
    logic [CW-1:0] pick_idx_reg, pick_idx_next;
    logic [W-1:0]  pick_bytes_reg, pick_bytes_next;
    logic [W-1:0]  pick_start_reg, pick_start_next;
    logic [W-1:0]  prev_bytes_reg, prev_bytes_next;
    logic          prev_free_reg, prev_free_next;
    logic          hit_reg, hit_next;
    logic          mp_reg, mp_next;
    logic          mn_reg, mn_next;
    logic          split_reg, split_next;
    logic          up_reg, up_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] used_reg, used_next;
    status_t       status_reg, status_next;
    logic [11:0]   offset_reg, offset_next;
    logic          out_valid_reg, out_valid_next;
    out_t          out_word_reg, out_word_next;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [W:0]    wr_data;
    logic [W:0]    rd_data;
    logic [W-1:0]  ev_bytes;
    logic          ev_free;
    logic          last;
    logic          fit;
    logic          take;
    logic [CW-1:0] k_cnt;
    logic [CW-1:0] src_idx;

    pba_ram #(
        .WIDTH (W + 1),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    assign ev_bytes  = rd_data[W-1:0];
    assign ev_free   = rd_data[W];
    assign last      = (idx_reg == count_reg - ONE);
    assign fit       = ev_free && (ev_bytes >= want_reg);
    assign take      = fit && (!found_reg || (op_reg == OP_BEST && ev_bytes < pick_bytes_reg));
    assign k_cnt     = CW'(mp_reg) + CW'(mn_reg);
    assign src_idx   = pick_idx_reg + ONE + CW'(mn_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Hold state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            count_reg     <= ONE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold request and walk payload
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        want_reg       <= want_next;
        addr_reg       <= addr_next;
        idx_reg        <= idx_next;
        start_reg      <= start_next;
        found_reg      <= found_next;
        pick_idx_reg   <= pick_idx_next;
        pick_bytes_reg <= pick_bytes_next;
        pick_start_reg <= pick_start_next;
        prev_bytes_reg <= prev_bytes_next;
        prev_free_reg  <= prev_free_next;
        hit_reg        <= hit_next;
        mp_reg         <= mp_next;
        mn_reg         <= mn_next;
        split_reg      <= split_next;
        up_reg         <= up_next;
        status_reg     <= status_next;
        offset_reg     <= offset_next;
        out_word_reg   <= out_word_next;
    end

    // Advance the sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        want_next       = want_reg;
        addr_next       = addr_reg;
        idx_next        = idx_reg;
        start_next      = start_reg;
        found_next      = found_reg;
        pick_idx_next   = pick_idx_reg;
        pick_bytes_next = pick_bytes_reg;
        pick_start_next = pick_start_reg;
        prev_bytes_next = prev_bytes_reg;
        prev_free_next  = prev_free_reg;
        hit_next        = hit_reg;
        mp_next         = mp_reg;
        mn_next         = mn_reg;
        split_next      = split_reg;
        up_next         = up_reg;
        count_next      = count_reg;
        used_next       = used_reg;
        status_next     = status_reg;
        offset_next     = offset_reg;
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[IW-1:0];
        wr_data         = rd_data;

        // Drop the result word once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = {1'b1, INIT_SZ};
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next        = in_word.operation;
                    want_next      = W'(in_word.request_size);
                    addr_next      = W'(in_word.free_addr);
                    idx_next       = '0;
                    start_next     = '0;
                    found_next     = 1'b0;
                    hit_next       = 1'b0;
                    prev_free_next = 1'b0;
                    mp_next        = 1'b0;
                    mn_next        = 1'b0;
                    split_next     = 1'b0;
                    offset_next    = '0;
                    status_next    = ST_OK;
                    state_next     = S_WRD;
                    if (in_word.operation == OP_FIRST || in_word.operation == OP_BEST)
                    begin
                        if (in_word.request_size == '0)
                        begin
                            status_next = ST_ZERO;
                            state_next  = S_DONE;
                        end
                    end
                    else if (in_word.operation == OP_FREE)
                    begin
                        if (in_word.free_addr == '0)
                        begin
                            status_next = ST_NULL;
                            state_next  = S_DONE;
                        end
                    end
                    else
                    begin
                        status_next = ST_INVALID;
                        state_next  = S_DONE;
                    end
                end
            end
            S_WRD:
            begin
                state_next = S_WEV;
            end
            S_WEV:
            begin
                idx_next   = idx_reg + ONE;
                state_next = S_WRD;
                if (op_reg != OP_FREE)
                begin
                    // Search for a fitting free block
                    start_next = start_reg + HDR + ev_bytes;
                    if (take)
                    begin
                        found_next      = 1'b1;
                        pick_idx_next   = idx_reg;
                        pick_bytes_next = ev_bytes;
                        pick_start_next = start_reg;
                    end
                    if (last || (take && op_reg == OP_FIRST))
                    begin
                        if (found_reg || take)
                        begin
                            state_next = S_PLAN;
                        end
                        else
                        begin
                            status_next = ST_NOFIT;
                            state_next  = S_DONE;
                        end
                    end
                end
                else if (!hit_reg)
                begin
                    // Look for the block whose user area starts at the address
                    if (start_reg + HDR == addr_reg)
                    begin
                        if (ev_free)
                        begin
                            status_next = ST_DOUBLE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            hit_next      = 1'b1;
                            pick_idx_next = idx_reg;
                            if (prev_free_reg)
                            begin
                                pick_bytes_next = prev_bytes_reg + HDR + ev_bytes;
                                mp_next         = 1'b1;
                            end
                            else
                            begin
                                pick_bytes_next = ev_bytes;
                            end
                            if (last)
                            begin
                                state_next = S_PLAN;
                            end
                        end
                    end
                    else
                    begin
                        prev_bytes_next = ev_bytes;
                        prev_free_next  = ev_free;
                        start_next      = start_reg + HDR + ev_bytes;
                        if (last)
                        begin
                            status_next = ST_INVALID;
                            state_next  = S_DONE;
                        end
                    end
                end
                else
                begin
                    // Absorb the following block when it is free
                    if (ev_free)
                    begin
                        pick_bytes_next = pick_bytes_reg + HDR + ev_bytes;
                        mn_next         = 1'b1;
                    end
                    state_next = S_PLAN;
                end
            end
            S_PLAN:
            begin
                if (op_reg != OP_FREE)
                begin
                    offset_next = 12'(pick_start_reg + HDR);
                    split_next  = (pick_bytes_reg > want_reg + HDR) && (count_reg < MAX_CNT);
                    if ((pick_bytes_reg > want_reg + HDR) && (count_reg < MAX_CNT))
                    begin
                        if (pick_idx_reg + ONE < count_reg)
                        begin
                            idx_next   = count_reg - ONE;
                            up_next    = 1'b1;
                            state_next = S_SHRD;
                        end
                        else
                        begin
                            state_next = S_FIN1;
                        end
                    end
                    else
                    begin
                        state_next = S_FIN2;
                    end
                end
                else if (k_cnt != '0 && src_idx < count_reg)
                begin
                    idx_next   = src_idx;
                    up_next    = 1'b0;
                    state_next = S_SHRD;
                end
                else
                begin
                    state_next = S_FIN2;
                end
            end
            S_SHRD:
            begin
                state_next = S_SHWR;
            end
            S_SHWR:
            begin
                // Move one block up or down the table
                wr_en = 1'b1;
                if (up_reg)
                begin
                    wr_addr = IW'(idx_reg + ONE);
                    if (idx_reg == pick_idx_reg + ONE)
                    begin
                        state_next = S_FIN1;
                    end
                    else
                    begin
                        idx_next   = idx_reg - ONE;
                        state_next = S_SHRD;
                    end
                end
                else
                begin
                    wr_addr = IW'(idx_reg - k_cnt);
                    if (last)
                    begin
                        state_next = S_FIN2;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ONE;
                        state_next = S_SHRD;
                    end
                end
            end
            S_FIN1:
            begin
                // Write the free remainder of a split
                wr_en      = 1'b1;
                wr_addr    = IW'(pick_idx_reg + ONE);
                wr_data    = {1'b1, pick_bytes_reg - want_reg - HDR};
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                // Write the claimed or released block
                wr_en = 1'b1;
                if (op_reg != OP_FREE)
                begin
                    wr_addr   = pick_idx_reg[IW-1:0];
                    wr_data   = {1'b0, split_reg ? want_reg : pick_bytes_reg};
                    used_next = used_reg + ONE;
                    if (split_reg)
                    begin
                        count_next = count_reg + ONE;
                    end
                end
                else
                begin
                    wr_addr    = IW'(pick_idx_reg - CW'(mp_reg));
                    wr_data    = {1'b1, pick_bytes_reg};
                    used_next  = used_reg - ONE;
                    count_next = count_reg - k_cnt;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_word_next.user_offset = offset_reg;
                    out_word_next.status      = status_reg;
                    out_word_next.used_blocks = 9'(used_reg);
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/pba_checker.sv
// Port checker for the pool block allocator and its bind to the top level.
module pba_checker
    import pba_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input in_t  in_word,
    input logic out_valid,
    input logic out_ready,
    input out_t out_word
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // A failed request carries no offset
    a_fail_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.status != ST_OK |-> out_word.user_offset == '0)
        else $error("failed request returned an offset");

    // One request at a time
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // A null or double free returns no offset
    a_free_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_word.status == ST_NULL || out_word.status == ST_DOUBLE)
        |-> out_word.user_offset == '0)
        else $error("free returned an offset");

endmodule

bind pool_block_allocator_top pba_checker u_pba_checker (.*);

FILE: dv/pba_checker.sv
// Checker for the pool block allocator: watches both channels, predicts and compares.
module pba_scoreboard
    import pba_pkg::*;
#(
    parameter int POOL_BYTES   = 4096,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_BLOCKS   = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_ready,
    input  in_t  in_word,
    input  logic out_valid,
    input  logic out_ready,
    input  out_t out_word,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow block table in address order
    int unsigned tbl_start [MAX_BLOCKS];
    int unsigned tbl_bytes [MAX_BLOCKS];
    bit          tbl_free  [MAX_BLOCKS];
    int unsigned tbl_count;

    out_t expected_words[$];

    function automatic int unsigned used_count();
        int unsigned n;
        n = 0;
        for (int unsigned i = 0; i < tbl_count; i++)
            if (!tbl_free[i]) n++;
        return n;
    endfunction

    // Carve block i after want bytes when the remainder holds a header and a byte and the table has room
    function automatic void carve_entry(int unsigned i, int unsigned want);
        if (tbl_bytes[i] <= want + HEADER_BYTES) return;
        if (tbl_count >= MAX_BLOCKS) return;
        for (int unsigned j = tbl_count; j > i + 1; j--)
        begin
            tbl_start[j] = tbl_start[j-1];
            tbl_bytes[j] = tbl_bytes[j-1];
            tbl_free[j]  = tbl_free[j-1];
        end
        tbl_start[i+1] = tbl_start[i] + HEADER_BYTES + want;
        tbl_bytes[i+1] = tbl_bytes[i] - want - HEADER_BYTES;
        tbl_free[i+1]  = 1'b1;
        tbl_bytes[i]   = want;
        tbl_count++;
    endfunction

    // Merge every adjacent free pair
    function automatic void merge_free();
        int unsigned i;
        i = 0;
        while (i + 1 < tbl_count)
        begin
            if (tbl_free[i] && tbl_free[i+1])
            begin
                tbl_bytes[i] += HEADER_BYTES + tbl_bytes[i+1];
                for (int unsigned j = i + 1; j + 1 < tbl_count; j++)
                begin
                    tbl_start[j] = tbl_start[j+1];
                    tbl_bytes[j] = tbl_bytes[j+1];
                    tbl_free[j]  = tbl_free[j+1];
                end
                tbl_count--;
            end
            else
                i++;
        end
    endfunction

    function automatic out_t predict_alloc(in_t req);
        out_t        res;
        int unsigned want, addr, pick, idx;
        bit          found;
        res    = '0;
        res.status = ST_OK;
        want   = req.request_size;
        addr   = req.free_addr;
        if (req.operation == OP_FIRST || req.operation == OP_BEST)
        begin
            if (want == 0)
                res.status = ST_ZERO;
            else
            begin
                found = 0;
                pick  = 0;
                for (int unsigned i = 0; i < tbl_count; i++)
                begin
                    if (tbl_free[i] && tbl_bytes[i] >= want)
                    begin
                        if (!found ||
                            (req.operation == OP_BEST && tbl_bytes[i] < tbl_bytes[pick]))
                        begin
                            pick  = i;
                            found = 1;
                        end
                        if (req.operation == OP_FIRST) break;
                    end
                end
                if (!found)
                    res.status = ST_NOFIT;
                else
                begin
                    carve_entry(pick, want);
                    tbl_free[pick]  = 1'b0;
                    res.user_offset = 12'(tbl_start[pick] + HEADER_BYTES);
                end
            end
        end
        else if (req.operation == OP_FREE)
        begin
            if (addr == 0)
                res.status = ST_NULL;
            else
            begin
                found = 0;
                idx   = 0;
                for (int unsigned i = 0; i < tbl_count; i++)
                    if (tbl_start[i] + HEADER_BYTES == addr)
                    begin
                        found = 1;
                        idx   = i;
                        break;
                    end
                if (!found)
                    res.status = ST_INVALID;
                else if (tbl_free[idx])
                    res.status = ST_DOUBLE;
                else
                begin
                    tbl_free[idx] = 1'b1;
                    merge_free();
                end
            end
        end
        else
            res.status = ST_INVALID;
        res.used_blocks = 9'(used_count());
        return res;
    endfunction

    assign pending = expected_words.size();

    // Predict on accepted requests, compare accepted results
    always @(posedge clk or negedge rst_n)
    begin
        out_t exp_w;
        if (!rst_n)
        begin
            tbl_count    = 1;
            tbl_start[0] = 0;
            tbl_bytes[0] = POOL_BYTES - HEADER_BYTES;
            tbl_free[0]  = 1'b1;
            expected_words.delete();
            fail_count   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word %h", out_word);
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (exp_w.user_offset !== out_word.user_offset ||
                        exp_w.status !== out_word.status ||
                        exp_w.used_blocks !== out_word.used_blocks)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected off=%0d st=%0d used=%0d, ",
                                      "got off=%0d st=%0d used=%0d"},
                                     exp_w.user_offset, exp_w.status, exp_w.used_blocks,
                                     out_word.user_offset, out_word.status,
                                     out_word.used_blocks);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_words.push_back(predict_alloc(in_word));
        end
    end
endmodule

FILE: dv/tb_pool_block_allocator_top.sv
// Testbench top for the pool block allocator: stimulus, idling and verdict.
module tb_pool_block_allocator_top;
    import pba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 40000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t  in_word = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_word;
    int   fail_count;
    int   pending;
    bit   quiet_phase = 0;
    bit   hold_off = 0;
    int   idle_cycles = 0;
    int unsigned live_offsets[$];

    always #10 clk = ~clk;

    pool_block_allocator_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
    );

    pba_scoreboard chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .fail_count(fail_count), .pending(pending)
    );

    // Track offsets handed out, so frees mostly hit live blocks
    always @(posedge clk)
    begin
        if (out_valid && out_ready && out_word.user_offset != 0)
            live_offsets.push_back(out_word.user_offset);
    end

    // Offer one word at a falling edge and hold it until accepted;
    // in_ready is steady between rising edges, so it tells whether
    // the coming edge takes the word
    task automatic send_word(logic [1:0] op, logic [12:0] sz, logic [11:0] addr);
        bit taken;
        in_word  = '{operation: op, request_size: sz, free_addr: addr};
        in_valid = 1'b1;
        taken    = 1'b0;
        while (!taken)
        begin
            taken = in_ready;
            @(negedge clk);
        end
        in_valid = 1'b0;
    endtask

    task automatic send_idle();
        if (!quiet_phase && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 17)) @(negedge clk);
    endtask

    task automatic send_random();
        int unsigned k, pick;
        k = $urandom_range(0, 99);
        if (k < 50)
            send_word(k < 25 ? OP_FIRST : OP_BEST, 13'($urandom_range(1, 120)), 12'($urandom));
        else if (k < 80 && live_offsets.size() > 0)
        begin
            pick = $urandom_range(0, live_offsets.size() - 1);
            send_word(OP_FREE, 13'($urandom), 12'(live_offsets[pick]));
            live_offsets.delete(pick);
        end
        else if (k < 88)
            send_word(2'($urandom_range(0, 1)), 13'($urandom), 12'($urandom));
        else if (k < 96)
            send_word(OP_FREE, 13'($urandom), 12'($urandom));
        else
            send_word(OP_RSVD, 13'($urandom), 12'($urandom));
    endtask

    // Receiver: random stalls, one long hold-off, none at the end
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (3000) @(negedge clk);
                hold_off = 0;
            end
            else if (!quiet_phase && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("pool_block_allocator_top test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // Directed: zero size, oversized, null, invalid, double free, unknown op
        send_word(OP_FIRST, 13'd0, 12'd0);
        send_word(OP_BEST, 13'd4096, 12'hFFF);
        send_word(OP_FIRST, 13'h1FFF, 12'd0);
        send_word(OP_FREE, 13'd0, 12'd0);
        send_word(OP_FREE, 13'h1FFF, 12'hFFF);
        send_word(OP_RSVD, 13'h1FFF, 12'hFFF);
        send_word(OP_FIRST, 13'd100, 12'd0);
        send_word(OP_FIRST, 13'd1, 12'd0);
        send_word(OP_BEST, 13'd50, 12'd0);
        send_word(OP_FREE, 13'd0, 12'd24);
        send_word(OP_FREE, 13'd0, 12'd24);
        send_word(OP_FREE, 13'd0, 12'd25);
        send_word(OP_BEST, 13'd60, 12'd0);
        send_word(OP_FREE, 13'd0, 12'd148);
        send_word(OP_FREE, 13'd0, 12'd24);
        send_word(OP_FREE, 13'd0, 12'd173);
        send_word(OP_FIRST, 13'd4072, 12'd0);
        send_word(OP_FREE, 13'd0, 12'd24);
        send_word(OP_BEST, 13'd4049, 12'd0);
        while (pending != 0) @(negedge clk);
        live_offsets.delete();
        // Fill the pool with tiny blocks until further requests find no fit
        for (int i = 0; i < 260; i++)
            send_word(OP_FIRST, 13'd1, 12'd0);
        hold_off = 1;
        for (int i = 0; i < 40; i++)
            send_word(OP_FREE, 13'd0, 12'(24 + 25 * $urandom_range(0, 160)));
        for (int i = 0; i < 600; i++)
        begin
            send_random();
            send_idle();
        end
        quiet_phase = 1;
        for (int i = 0; i < 250; i++)
            send_random();
        while (pending != 0) @(negedge clk);
        repeat (1100) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("pool_block_allocator_top test passed");
        else
            $display("pool_block_allocator_top test failed");
        $finish;
    end
endmodule
